FILE: rtl/core/aftdp_pkg.sv
// ----------------------------------------------------------------------------
// aftdp_pkg
// Shared types and constants for the serial data frame parser.
// ----------------------------------------------------------------------------
package aftdp_pkg;

  // Longest payload accepted; a longer length field drops the frame.
  localparam int unsigned MAX_PAYLOAD = 32;
  localparam logic [7:0]  MAX_LEN     = 8'(MAX_PAYLOAD);

  // Captured payload bytes 1..7 (byte 0, the channel, is not kept).
  localparam int unsigned CAP_DEPTH = 7;

  localparam logic [7:0] SYNC_BYTE   = 8'hA4;
  localparam logic [7:0] ID_BCAST    = 8'h4E;
  localparam logic [7:0] ID_ACK      = 8'h4F;
  localparam logic [7:0] PAGE_SPEED  = 8'h10;
  localparam logic [7:0] PAGE_POWER  = 8'h19;
  localparam logic [7:0] NO_CADENCE  = 8'hFF;

  typedef enum logic [1:0] {
    KIND_SPEED = 2'd0,
    KIND_POWER = 2'd1,
    KIND_OTHER = 2'd2
  } frame_kind_e;

  // Framing phases, one-hot.
  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_LEN     = 5'b00010,
    PH_ID      = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_CHECK   = 5'b10000
  } phase_e;

  // One result beat as handed from the parser to the output stage.
  typedef struct packed {
    logic [1:0]  frame_kind;
    logic [15:0] speed_raw;
    logic [11:0] power_watts;
    logic [7:0]  cadence_rpm;
    logic        link_up;
  } res_t;

endpackage

FILE: rtl/core/aftdp_byte_if.sv
// ----------------------------------------------------------------------------
// aftdp_byte_if
// Valid/ready channel carrying one received stream byte per beat.
// ----------------------------------------------------------------------------
interface aftdp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/core/aftdp_res_if.sv
// ----------------------------------------------------------------------------
// aftdp_res_if
// Valid/ready channel carrying one parsed data frame result per beat.
// ----------------------------------------------------------------------------
interface aftdp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_kind;
  logic [15:0] speed_raw;
  logic [11:0] power_watts;
  logic [7:0]  cadence_rpm;
  logic        link_up;

  modport source (output valid, output frame_kind, output speed_raw, output power_watts,
                  output cadence_rpm, output link_up, input ready);
  modport sink   (input valid, input frame_kind, input speed_raw, input power_watts,
                  input cadence_rpm, input link_up, output ready);
endinterface

FILE: rtl/core/aftdp_parser.sv
// ----------------------------------------------------------------------------
// aftdp_parser
// Framing state machine, checksum, payload capture and held trainer values.
// ----------------------------------------------------------------------------
module aftdp_parser
  import aftdp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,     // consume byte_i this cycle
  input  logic [7:0] byte_i,
  output logic       res_vld_o,  // one cycle, with step_i
  output res_t       res_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  code_q, code_d;
  logic [15:0] speed_q, speed_d;
  logic [11:0] power_q, power_d;
  logic [7:0]  cad_q, cad_d;
  logic        link_q, link_d;
  logic [7:0]  cap_q [CAP_DEPTH];
  logic [8:0]  cnt_inc;
  logic        is_data;
  logic        cap_clr;
  logic        cap_wr;
  logic [1:0]  kind;

  assign cnt_inc = {1'b0, cnt_q} + 9'd1;
  assign is_data = (code_q == ID_BCAST) || (code_q == ID_ACK);

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    xor_d     = xor_q;
    code_d    = code_q;
    speed_d   = speed_q;
    power_d   = power_q;
    cad_d     = cad_q;
    link_d    = link_q;
    cap_clr   = 1'b0;
    cap_wr    = 1'b0;
    res_vld_o = 1'b0;
    kind      = KIND_OTHER;
    if (step_i) begin
      unique case (phase_q)
        PH_LEN: begin
          xor_d   = xor_q ^ byte_i;
          len_d   = byte_i;
          phase_d = (byte_i > MAX_LEN) ? PH_HUNT : PH_ID;
        end
        PH_ID: begin
          xor_d   = xor_q ^ byte_i;
          code_d  = byte_i;
          cnt_d   = '0;
          phase_d = (len_q == '0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          xor_d  = xor_q ^ byte_i;
          cap_wr = 1'b1;
          cnt_d  = cnt_inc[7:0];
          if (cnt_inc >= {1'b0, len_q}) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase_d = PH_HUNT;
          if ((byte_i == xor_q) && is_data) begin
            res_vld_o = 1'b1;
            link_d    = 1'b1;
            if (cap_q[0] == PAGE_SPEED) begin
              speed_d = {cap_q[5], cap_q[4]};
              kind    = KIND_SPEED;
            end else if (cap_q[0] == PAGE_POWER) begin
              power_d = {cap_q[6][3:0], cap_q[5]};
              if (cap_q[2] != NO_CADENCE) begin
                cad_d = cap_q[2];
              end
              kind = KIND_POWER;
            end
          end
        end
        default: begin
          if (byte_i == SYNC_BYTE) begin
            xor_d   = byte_i;
            cnt_d   = '0;
            cap_clr = 1'b1;
            phase_d = PH_LEN;
          end else begin
            phase_d = PH_HUNT;
          end
        end
      endcase
    end
  end

  assign res_o = '{frame_kind: kind, speed_raw: speed_d, power_watts: power_d,
                   cadence_rpm: cad_d, link_up: link_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cnt_q   <= '0;
      len_q   <= '0;
      xor_q   <= '0;
      code_q  <= '0;
      speed_q <= '0;
      power_q <= '0;
      cad_q   <= '0;
      link_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      xor_q   <= xor_d;
      code_q  <= code_d;
      speed_q <= speed_d;
      power_q <= power_d;
      cad_q   <= cad_d;
      link_q  <= link_d;
    end
  end

  // Payload bytes 1..7 land in entries 0..6; every sync clears them.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAP_DEPTH; i++) begin
      if (cap_clr) begin
        cap_q[i] <= '0;
      end else if (cap_wr && (cnt_q == 8'(i + 1))) begin
        cap_q[i] <= byte_i;
      end
    end
  end

  // Link flag, once set, stays set until reset.
  a_link_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link_q |=> link_q)
    else $error("link flag dropped");

  // A result comes only from the checksum byte of a data frame.
  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o |-> (phase_q == PH_CHECK) && is_data && step_i)
    else $error("result outside checksum phase");

endmodule

FILE: rtl/core/aftdp_out_stage.sv
// ----------------------------------------------------------------------------
// aftdp_out_stage
// Result register towards the output channel.
// ----------------------------------------------------------------------------
module aftdp_out_stage
  import aftdp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  load_i,
  input  res_t  res_i,
  output logic  free_o,   // register empty or drained this cycle
  aftdp_res_if.source res_o
);

  logic vld_q, vld_d;
  res_t res_q;

  assign free_o = !vld_q || res_o.ready;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (res_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid       = vld_q;
  assign res_o.frame_kind  = res_q.frame_kind;
  assign res_o.speed_raw   = res_q.speed_raw;
  assign res_o.power_watts = res_q.power_watts;
  assign res_o.cadence_rpm = res_q.cadence_rpm;
  assign res_o.link_up     = res_q.link_up;

  // Never overwrite a beat that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result overwritten while stalled");

  // Every result carries the link flag set.
  a_link_in_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> res_q.link_up)
    else $error("result without link flag");

endmodule

FILE: rtl/core/ant_frame_trainer_data_parser_top.sv
// ----------------------------------------------------------------------------
// ant_frame_trainer_data_parser_top
// Sync-framed serial message parser extracting trainer speed, power, cadence.
// ----------------------------------------------------------------------------
//  channel | dir | beat                      | payload
//  --------+-----+---------------------------+----------------------------------
//  rx_i    | in  | one stream byte           | rx_byte
//  res_o   | out | one valid data frame      | frame_kind, speed_raw,
//          |     |                           | power_watts, cadence_rpm, link_up
//
//  One byte per cycle sustained while res_o is not stalled; each byte passes
//  input register -> framing logic -> result register. The checksum byte is
//  registered, then its result loads the result register when the pipe moves.
//  Reset (rst_ni, async low) returns to sync hunting with all held values zero.
//  A stall on res_o holds the input register; rx_i.ready then drops once the
//  input register is full as well. No result beat is ever lost or doubled.
// ----------------------------------------------------------------------------
module ant_frame_trainer_data_parser_top
  import aftdp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  aftdp_byte_if.sink  rx_i,
  aftdp_res_if.source res_o
);

  // Input register.
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       rx_take;

  // Pipeline advance: the result register can take whatever this byte yields.
  logic       adv;
  logic       step;
  logic       res_vld;
  res_t       res;

  assign step       = in_vld_q && adv;
  assign rx_i.ready = !in_vld_q || adv;
  assign rx_take    = rx_i.valid && rx_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (rx_take) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_take) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  // Framing logic consumes the registered byte when the pipe moves.
  aftdp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (in_byte_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  aftdp_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (res_vld),
    .res_i  (res),
    .free_o (adv),
    .res_o  (res_o)
  );

endmodule

FILE: verif/tb_ant_frame_trainer_data_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ant_frame_trainer_data_parser_top
// Self-checking bench for the sync-framed data frame parser. Stream bytes are
// fed through a directed frame table and then through randomised frames.
// Every accepted byte is run through a local copy of the framing logic, and
// each result beat is compared field by field with the oldest frame due.
// ----------------------------------------------------------------------------
module tb_ant_frame_trainer_data_parser_top;
  import aftdp_pkg::*;

  // Stream bytes in the random part; frames are generated until this is passed.
  localparam int unsigned N_RANDOM    = 730;
  // Cycles with no beat on either channel before the run is declared hung.
  localparam int unsigned QUIET_LIMIT = 4000;
  // Extra drain after the last owed result arrives, to catch stray beats.
  localparam int unsigned DRAIN       = 8;
  localparam int unsigned MAX_SHOWN   = 50;

  // How the checksum byte of a frame is checked.
  typedef enum logic [1:0] {
    CHK_MODEL = 2'd0,  // result, if any, worked out by the frame predictor
    CHK_NONE  = 2'd1,  // no result may come from this frame
    CHK_RES   = 2'd2   // result typed into the table
  } check_e;

  typedef struct packed {
    logic            has_lead;  // send a noise byte ahead of the sync
    logic [7:0]      lead;
    logic [7:0]      len;
    logic [7:0]      id;
    logic [0:8][7:0] pay;       // payload bytes 0..8; later bytes are filler
    logic [7:0]      flip;      // XORed into the correct checksum
    check_e          chk;
    res_t            res;
  } frame_row_t;

  // --------------------------------------------------------------------------
  // Directed frames. Payload byte 0 is the channel, byte 1 the data page.
  // Speed page: bytes 5/6. Power page: cadence byte 3, power bytes 6/7[3:0].
  // --------------------------------------------------------------------------
  localparam int unsigned N_DIR = 14;
  frame_row_t frame_tab [N_DIR] = '{
    // first frame after reset: all holds still zero, link comes up
    '{1'b1, 8'h00, 8'd8, ID_BCAST, 72'h00_00_00_00_00_00_00_00_00, 8'h00, CHK_RES,
      '{KIND_OTHER, 16'h0000, 12'h000, 8'h00, 1'b1}},
    // speed at its top value, acknowledged id
    '{1'b1, 8'hFF, 8'd8, ID_ACK,   72'h01_10_FF_FF_FF_FF_FF_FF_00, 8'h00, CHK_RES,
      '{KIND_SPEED, 16'hFFFF, 12'h000, 8'h00, 1'b1}},
    // power at its top value, top cadence
    '{1'b0, 8'h00, 8'd8, ID_BCAST, 72'h02_19_00_FE_00_00_FF_FF_00, 8'h00, CHK_RES,
      '{KIND_POWER, 16'hFFFF, 12'hFFF, 8'hFE, 1'b1}},
    // cadence field 0xFF leaves cadence held; upper nibble of byte 7 masked
    '{1'b0, 8'h00, 8'd8, ID_ACK,   72'h03_19_00_FF_00_00_00_F0_00, 8'h00, CHK_RES,
      '{KIND_POWER, 16'hFFFF, 12'h000, 8'hFE, 1'b1}},
    // bad checksum: dropped, nothing changes
    '{1'b0, 8'h00, 8'd8, ID_BCAST, 72'h00_10_00_00_00_77_77_00_00, 8'h01, CHK_NONE,
      '{KIND_OTHER, 16'h0000, 12'h000, 8'h00, 1'b0}},
    // frame right behind the dropped one is parsed
    '{1'b0, 8'h00, 8'd8, ID_BCAST, 72'h00_10_00_00_00_34_12_00_00, 8'h00, CHK_RES,
      '{KIND_SPEED, 16'h1234, 12'h000, 8'hFE, 1'b1}},
    // valid frame of some other message id
    '{1'b0, 8'h00, 8'd8, 8'h46,    72'h00_10_00_00_00_55_55_00_00, 8'h00, CHK_NONE,
      '{KIND_OTHER, 16'h0000, 12'h000, 8'h00, 1'b0}},
    // length one past the limit: only sync and length go out
    '{1'b0, 8'h00, MAX_LEN + 8'd1, ID_BCAST, 72'h0, 8'h00, CHK_NONE,
      '{KIND_OTHER, 16'h0000, 12'h000, 8'h00, 1'b0}},
    // zero length: id straight into checksum
    '{1'b0, 8'h00, 8'd0, ID_ACK,   72'h0, 8'h00, CHK_MODEL, '0},
    // too short to carry a page
    '{1'b0, 8'h00, 8'd1, ID_BCAST, 72'h05_00_00_00_00_00_00_00_00, 8'h00, CHK_MODEL, '0},
    // short speed page, sync value as payload
    '{1'b0, 8'h00, 8'd3, ID_BCAST, 72'h00_10_A4_00_00_00_00_00_00, 8'h00, CHK_MODEL, '0},
    // sync value all through the payload
    '{1'b0, 8'h00, 8'd9, ID_BCAST, 72'hA4_19_A4_A4_A4_A4_A4_A4_A4, 8'h00, CHK_MODEL, '0},
    // longest payload allowed
    '{1'b0, 8'h00, MAX_LEN, ID_ACK, 72'h07_19_11_22_33_44_55_66_77, 8'h00, CHK_MODEL, '0},
    // unknown page, all ones
    '{1'b1, 8'h00, 8'd8, ID_BCAST, 72'hFF_0F_FF_FF_FF_FF_FF_FF_FF, 8'h00, CHK_MODEL, '0}
  };

  logic clk_i;
  logic rst_ni;

  aftdp_byte_if rx_if ();
  aftdp_res_if  res_if ();

  ant_frame_trainer_data_parser_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  // Results owed by the DUT, oldest first.
  res_t        due_results [$];
  logic [7:0]  pay_q [$];

  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned quiet         = 0;
  int unsigned n_errors      = 0;
  int unsigned n_bytes       = 0;
  int unsigned n_frames      = 0;
  int unsigned n_checked     = 0;
  int unsigned n_kind [3]    = '{0, 0, 0};

  // --------------------------------------------------------------------------
  // Frame predictor: own copy of the framing state and the held values.
  // --------------------------------------------------------------------------
  phase_e      fp_phase = PH_HUNT;
  logic [7:0]  fp_count = '0;
  logic [7:0]  fp_len   = '0;
  logic [7:0]  fp_xor   = '0;
  logic [7:0]  fp_id    = '0;
  logic [7:0]  fp_cap [CAP_DEPTH];   // payload bytes 1..7
  logic [15:0] hold_speed   = '0;
  logic [11:0] hold_power   = '0;
  logic [7:0]  hold_cadence = '0;

  // Advances the predictor by one byte; returns 1 when a result is due.
  function automatic bit parse_byte(input logic [7:0] b, output res_t r);
    frame_kind_e kind;
    r = '0;
    case (fp_phase)
      PH_LEN: begin
        fp_xor   ^= b;
        fp_len   = b;
        fp_phase = (b > MAX_LEN) ? PH_HUNT : PH_ID;
      end
      PH_ID: begin
        fp_xor   ^= b;
        fp_id    = b;
        fp_count = '0;
        fp_phase = (fp_len == 8'd0) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        fp_xor ^= b;
        if (fp_count >= 8'd1 && fp_count <= 8'(CAP_DEPTH)) fp_cap[fp_count - 8'd1] = b;
        fp_count = fp_count + 8'd1;
        if (fp_count >= fp_len) fp_phase = PH_CHECK;
      end
      PH_CHECK: begin
        fp_phase = PH_HUNT;
        if (b == fp_xor && (fp_id == ID_BCAST || fp_id == ID_ACK)) begin
          kind = KIND_OTHER;
          if (fp_cap[0] == PAGE_SPEED) begin
            hold_speed = {fp_cap[5], fp_cap[4]};
            kind       = KIND_SPEED;
          end else if (fp_cap[0] == PAGE_POWER) begin
            hold_power = {fp_cap[6][3:0], fp_cap[5]};
            if (fp_cap[2] != NO_CADENCE) hold_cadence = fp_cap[2];
            kind = KIND_POWER;
          end
          r = '{kind, hold_speed, hold_power, hold_cadence, 1'b1};
          return 1'b1;
        end
      end
      default: begin
        // hunting: anything but sync is skipped
        if (b == SYNC_BYTE) begin
          fp_xor   = b;
          fp_count = '0;
          foreach (fp_cap[i]) fp_cap[i] = '0;
          fp_phase = PH_LEN;
        end else begin
          fp_phase = PH_HUNT;
        end
      end
    endcase
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what);
    n_errors++;
    if (n_errors <= MAX_SHOWN) $display("[%0t] MISMATCH %s", $time, what);
  endtask

  // One byte beat on rx; random idle cycles ahead of it. The predictor
  // advances when the beat is taken.
  task automatic send_byte(input logic [7:0] b, input bit use_model);
    res_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    n_bytes++;
    if (parse_byte(b, r) && use_model) due_results.push_back(r);
  endtask

  // Sync, length, id, payload from pay_q, checksum. Oversized frames stop
  // after the length byte.
  task automatic send_frame(input logic [7:0] len, input logic [7:0] id,
                            input logic [7:0] flip, input check_e chk, input res_t typed);
    logic [7:0] sum;
    sum = SYNC_BYTE ^ len;
    n_frames++;
    send_byte(SYNC_BYTE, 1'b1);
    send_byte(len, 1'b1);
    if (len > MAX_LEN) return;
    send_byte(id, 1'b1);
    sum ^= id;
    for (int i = 0; i < int'(len); i++) begin
      send_byte(pay_q[i], 1'b1);
      sum ^= pay_q[i];
    end
    send_byte(sum ^ flip, chk == CHK_MODEL);
    if (chk == CHK_RES) due_results.push_back(typed);
  endtask

  // Mostly well-formed data frames with random content; the rest is noise,
  // foreign ids, oversized lengths and corrupted checksums.
  task automatic random_frame();
    int unsigned n_lead;
    int unsigned len;
    int unsigned pick;
    logic [7:0]  id;
    logic [7:0]  flip;
    pay_q.delete();
    n_lead = ($urandom_range(9) < 3) ? $urandom_range(1, 3) : 0;
    repeat (n_lead) send_byte(8'($urandom), 1'b1);
    pick = $urandom_range(99);
    if (pick < 55)      len = 8;
    else if (pick < 75) len = $urandom_range(0, 9);
    else if (pick < 92) len = $urandom_range(10, MAX_PAYLOAD);
    else                len = $urandom_range(MAX_PAYLOAD + 1, 255);
    if ($urandom_range(99) < 85) id = $urandom_range(1) ? ID_BCAST : ID_ACK;
    else                         id = 8'($urandom);
    for (int i = 0; i < int'(len); i++) pay_q.push_back(8'($urandom));
    if (len > 1) begin
      pick = $urandom_range(9);
      if (pick < 4)      pay_q[1] = PAGE_SPEED;
      else if (pick < 8) pay_q[1] = PAGE_POWER;
    end
    if (len > 3 && $urandom_range(3) == 0) pay_q[3] = NO_CADENCE;
    flip = ($urandom_range(9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    send_frame(8'(len), id, flip, CHK_MODEL, '0);
  endtask

  // --------------------------------------------------------------------------
  // Clock, 2 ns period.
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, check each beat, and keep the count of
  // cycles without any beat for the watchdog.
  // --------------------------------------------------------------------------
  initial begin
    res_t want;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
      if (rst_ni && res_if.valid && res_if.ready) begin
        n_checked++;
        if (res_if.frame_kind < 2'd3) n_kind[res_if.frame_kind]++;
        if (due_results.size() == 0) begin
          report_mismatch("result beat with no frame due");
        end else begin
          want = due_results.pop_front();
          if (res_if.frame_kind !== want.frame_kind)
            report_mismatch($sformatf("frame_kind got %0d want %0d",
                                      res_if.frame_kind, want.frame_kind));
          if (res_if.speed_raw !== want.speed_raw)
            report_mismatch($sformatf("speed_raw got %h want %h",
                                      res_if.speed_raw, want.speed_raw));
          if (res_if.power_watts !== want.power_watts)
            report_mismatch($sformatf("power_watts got %h want %h",
                                      res_if.power_watts, want.power_watts));
          if (res_if.cadence_rpm !== want.cadence_rpm)
            report_mismatch($sformatf("cadence_rpm got %h want %h",
                                      res_if.cadence_rpm, want.cadence_rpm));
          if (res_if.link_up !== want.link_up)
            report_mismatch($sformatf("link_up got %b want %b",
                                      res_if.link_up, want.link_up));
        end
      end
      res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Watchdog: a long stretch without a beat means the DUT has hung.
  initial begin
    wait (quiet >= QUIET_LIMIT);
    $display("watchdog: %0d cycles without a beat, %0d results still due",
             quiet, due_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus: reset, directed frames, then random frames over idle phases.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned rand_base;
    int unsigned seg;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    rst_ni        <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, no idling on either side
    for (int k = 0; k < N_DIR; k++) begin
      pay_q.delete();
      if (frame_tab[k].has_lead) send_byte(frame_tab[k].lead, 1'b1);
      for (int i = 0; i < int'(frame_tab[k].len) && i <= int'(MAX_PAYLOAD); i++)
        pay_q.push_back(i < 9 ? frame_tab[k].pay[i] : 8'(i * 37));
      send_frame(frame_tab[k].len, frame_tab[k].id, frame_tab[k].flip,
                 frame_tab[k].chk, frame_tab[k].res);
    end

    // random part: eight segments, each idle phase twice
    rand_base = n_bytes;
    while (n_bytes - rand_base < N_RANDOM) begin
      seg = ((n_bytes - rand_base) * 8 / N_RANDOM) % 4;
      case (seg)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 53; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 53; end
        default: begin src_idle_pct = 14; snk_stall_pct = 14; end
      endcase
      random_frame();
    end
    rx_if.valid <= 1'b0;

    // let every owed result arrive, then a short drain for stray beats
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("covered %0d stream bytes in %0d frames (%0d from the directed table)",
             n_bytes, n_frames, N_DIR);
    $display("checked %0d results: %0d speed, %0d power, %0d other; %0d mismatches",
             n_checked, n_kind[0], n_kind[1], n_kind[2], n_errors);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
